// File: design/plts_pkg.sv
package plts_pkg;

    localparam int TASK_COUNT_DEF = 8;
    localparam int IDLE_INDEX_DEF = 0;
    localparam int IDX_W          = 4;
    localparam int PRIO_W         = 4;
    localparam int TIME_W         = 32;
    localparam int REG_TASKS      = 8;
    localparam logic [31:0] PRIO_RESET = 32'hFFF2_111F;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_SLEEPING = 2'd2
    } t_task_state;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              set_en;
        logic [IDX_W-1:0]  set_idx;
        t_task_state       new_state;
        logic [TIME_W-1:0] wake_at;
        logic              tick;
        logic [TIME_W-1:0] now_time;
        logic              cur_valid;
        logic [IDX_W-1:0]  cur_idx;
    } t_cell_cmd;

    // best-so-far record handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  best;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] last_run;
    } t_tok;

endpackage

// File: design/priority_lru_task_scheduler_unit.sv
// schedule requests: the best-so-far record walks the registered cell row task by task and
//   its pick lands in the output register; o_stall is high while the walk runs, so no new
//   request is taken while a walk is in flight
// set-state requests give no result
// reset (synchronous, active low): all tasks ready, times zero, no current task,
//   priority register at its reset value
module priority_lru_task_scheduler_unit
    import plts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF,
    parameter int IDLE_INDEX = IDLE_INDEX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_time,
    input  logic [2:0]  i_task_index,
    input  logic [1:0]  i_new_state,
    input  logic [31:0] i_wake_at,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_chosen_task,
    output logic        o_idle_fallback,
    // priority register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    // control
    logic              r_busy;
    logic              r_start;
    logic              r_cur_valid;
    logic [IDX_W-1:0]  r_cur_idx;
    logic [31:0]       r_prio;
    // output register
    logic              r_out_valid;
    logic [2:0]        r_chosen;
    logic              r_idle;

    logic              w_accept;
    logic              w_set_ok;
    logic              w_hold;
    logic              w_drain;
    t_cell_cmd         w_cmd;
    t_tok              w_tok_in  [TASK_COUNT];
    t_tok              w_tok_out [TASK_COUNT];
    logic [TASK_COUNT-1:0] w_tok_valid;
    t_tok              w_final;

    // requests are held off while a schedule walk is in flight
    assign o_stall     = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !r_busy;

    // ignore an undefined state code or a task beyond the table
    assign w_set_ok = (i_new_state != 2'd3) && (int'(i_task_index) < TASK_COUNT);

    always_comb begin
        w_cmd           = '0;
        w_cmd.set_en    = w_accept && i_action && w_set_ok;
        w_cmd.set_idx   = {1'b0, i_task_index};
        w_cmd.new_state = t_task_state'(i_new_state);
        w_cmd.wake_at   = i_wake_at;
        w_cmd.tick      = w_accept && !i_action;
        w_cmd.now_time  = i_now_time;
        w_cmd.cur_valid = r_cur_valid;
        w_cmd.cur_idx   = r_cur_idx;
    end

    // the walk enters cell zero the cycle after the tick updated every cell
    always_comb begin
        w_tok_in[0]       = '0;
        w_tok_in[0].valid = r_start;
    end

    assign w_final = w_tok_out[TASK_COUNT-1];
    // last cell keeps its finished record while the output register is full and stalled;
    // a record still on its way in must not be held back
    assign w_hold  = w_final.valid && r_out_valid && i_stall;
    assign w_drain = w_final.valid && !w_hold;

    genvar k;
    generate
        for (k = 0; k < TASK_COUNT; k++) begin : g_cell
            logic [PRIO_W-1:0] w_prio;
            // tasks beyond the register's eight nibbles get the lowest priority
            if (k < REG_TASKS) begin : g_reg
                assign w_prio = r_prio[PRIO_W*k +: PRIO_W];
            end else begin : g_fix
                assign w_prio = {PRIO_W{1'b1}};
            end
            if (k > 0) begin : g_link
                assign w_tok_in[k] = w_tok_out[k-1];
            end
            assign w_tok_valid[k] = w_tok_out[k].valid;

            plts_cell #(
                .CELL_IDX(k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (w_cmd),
                .i_prio (w_prio),
                .i_hold ((k == TASK_COUNT-1) ? w_hold : 1'b0),
                .i_tok  (w_tok_in[k]),
                .o_tok  (w_tok_out[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_cur_valid <= 1'b0;
            r_cur_idx   <= '0;
            r_prio      <= PRIO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_accept && !i_action;
            if (w_accept && !i_action) begin
                r_busy <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_prio <= i_cfg_data;
            end
            if (w_drain) begin
                // walk done: the pick becomes the current task
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_cur_valid <= 1'b1;
                r_cur_idx   <= w_final.found ? w_final.best : IDX_W'(IDLE_INDEX);
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_chosen <= w_final.found ? w_final.best[2:0] : 3'(IDLE_INDEX);
            r_idle   <= !w_final.found;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_chosen_task   = r_chosen;
    assign o_idle_fallback = r_idle;

    // only one walk in flight
    a_one_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_valid, r_start}))
        else $error("more than one schedule walk in the cell row");

    // nothing travels the row while idle
    a_idle_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_tok_valid == '0) && !r_start)
        else $error("walk record present while not busy");

    // a tick starts a walk in the next cycle
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_action) |=> r_start && r_busy)
        else $error("schedule request did not start a walk");

    // a real pick always names an existing task
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drain && w_final.found |-> int'(w_final.best) < TASK_COUNT)
        else $error("picked task beyond the table");

endmodule

// File: design/plts_cell.sv
module plts_cell
    import plts_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic [PRIO_W-1:0] i_prio,
    input  logic              i_hold,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    t_task_state       r_state, n_state;
    logic [TIME_W-1:0] r_wake, n_wake;
    logic [TIME_W-1:0] r_last, n_last;
    t_tok              r_tok, n_tok;
    logic              w_take;

    always_comb begin
        n_state = r_state;
        n_wake  = r_wake;
        n_last  = r_last;
        if (i_cmd.set_en && (i_cmd.set_idx == IDX_W'(CELL_IDX))) begin
            n_state = i_cmd.new_state;
            if (i_cmd.new_state == ST_SLEEPING) begin
                n_wake = i_cmd.wake_at;
            end
        end
        if (i_cmd.tick) begin
            // wake first, then stamp the running current task
            if ((r_state == ST_SLEEPING) && (i_cmd.now_time >= r_wake)) begin
                n_state = ST_READY;
            end
            if (i_cmd.cur_valid && (i_cmd.cur_idx == IDX_W'(CELL_IDX)) &&
                (r_state == ST_RUNNING)) begin
                n_last = i_cmd.now_time;
            end
        end
    end

    // strict compares keep the lower index on a full tie
    assign w_take = (r_state == ST_READY) &&
                    (!i_tok.found || (i_prio < i_tok.prio) ||
                     ((i_prio == i_tok.prio) && (r_last < i_tok.last_run)));

    always_comb begin
        n_tok = i_tok;
        if (w_take) begin
            n_tok.found    = 1'b1;
            n_tok.best     = IDX_W'(CELL_IDX);
            n_tok.prio     = i_prio;
            n_tok.last_run = r_last;
        end
        if (i_hold) begin
            n_tok = r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_wake      <= '0;
            r_last      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wake  <= n_wake;
            r_last  <= n_last;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: verif/tb.sv
module tb;
    import plts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // table size as the block is built
    localparam int NT = TASK_COUNT_DEF;

    // request kinds carried on i_action
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    // state code that the block must ignore
    localparam logic [1:0] ST_BAD = 2'd3;

    // cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // long receiver hold-off that backs the block up
    localparam int HOLD_CYCLES = 150;
    // settle time after the last request, one schedule walk plus margin
    localparam int SETTLE_CYCLES = NT + 6;

    typedef struct {
        logic        action;
        logic [31:0] now_time;
        logic [2:0]  task_index;
        logic [1:0]  new_state;
        logic [31:0] wake_at;
    } t_sched_req;

    typedef struct {
        logic [2:0] chosen;
        logic       idle;
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_TICK;
    logic [31:0] i_now_time = '0;
    logic [2:0]  i_task_index = '0;
    logic [1:0]  i_new_state = '0;
    logic [31:0] i_wake_at = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_chosen_task;
    logic        o_idle_fallback;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    priority_lru_task_scheduler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_now_time     (i_now_time),
        .i_task_index   (i_task_index),
        .i_new_state    (i_new_state),
        .i_wake_at      (i_wake_at),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chosen_task  (o_chosen_task),
        .o_idle_fallback(o_idle_fallback),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // pending requests and the picks they should produce
    t_sched_req req_q[$];
    t_pick      pick_q[$];

    // scheduler shadow state
    logic [31:0] prio_reg;
    t_task_state task_st[NT];
    logic [31:0] task_wake[NT];
    logic [31:0] task_last[NT];
    int          cur_task;
    bit          cur_valid;

    // bookkeeping
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken = 0;
    int unsigned ticks_taken = 0;
    int unsigned picks_checked = 0;
    int unsigned idle_picks = 0;
    int unsigned prio_writes = 0;
    int unsigned fails = 0;
    int          quiet = 0;
    bit          req_fire = 1'b0;

    // idling control, odds in percent per cycle of starting a burst
    int tx_odds = 0;
    int rx_odds = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_trig = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // well-formed traffic keeps its own rising notion of time
    logic [31:0] base_now = 32'd100;

    function automatic logic [3:0] prio_of(input int idx);
        if (idx >= 8)
            return 4'hF;
        return prio_reg[4*idx +: 4];
    endfunction

    // one accepted request through the scheduler, queuing the pick it makes
    task automatic schedule_step(input t_sched_req r);
        int    best;
        bit    found;
        t_pick p;
        best = 0;
        found = 1'b0;
        if (r.action == ACT_SET) begin
            // unknown state code or task outside the table: no effect
            if (r.new_state <= ST_SLEEPING && int'(r.task_index) < NT) begin
                task_st[r.task_index] = t_task_state'(r.new_state);
                // wake time only kept when going to sleep
                if (r.new_state == ST_SLEEPING)
                    task_wake[r.task_index] = r.wake_at;
            end
            return;
        end
        ticks_taken++;
        // wake-ups first, wake time at or before now counts
        for (int i = 0; i < NT; i++) begin
            if (task_st[i] == ST_SLEEPING && r.now_time >= task_wake[i])
                task_st[i] = ST_READY;
        end
        // stamp the current task only while it is marked running
        if (cur_valid && cur_task < NT && task_st[cur_task] == ST_RUNNING)
            task_last[cur_task] = r.now_time;
        // lowest priority number, then oldest last run, then lowest index
        for (int i = 0; i < NT; i++) begin
            if (task_st[i] != ST_READY)
                continue;
            if (!found || prio_of(i) < prio_of(best) ||
                (prio_of(i) == prio_of(best) && task_last[i] < task_last[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        if (found) begin
            cur_task = best;
            p.chosen = 3'(best);
            p.idle = 1'b0;
        end else begin
            // idle fallback regardless of the idle task's own state
            cur_task = IDLE_INDEX_DEF;
            p.chosen = 3'(IDLE_INDEX_DEF);
            p.idle = 1'b1;
        end
        cur_valid = 1'b1;
        pick_q.push_back(p);
    endtask

    function automatic t_sched_req tick_req(input logic [31:0] now_time);
        t_sched_req r;
        r.action = ACT_TICK;
        r.now_time = now_time;
        r.task_index = 3'($urandom_range(0, 7));
        r.new_state = 2'($urandom_range(0, 3));
        r.wake_at = $urandom;
        return r;
    endfunction

    function automatic t_sched_req set_req(input int idx, input logic [1:0] st,
                                           input logic [31:0] wake);
        t_sched_req r;
        r.action = ACT_SET;
        r.now_time = $urandom;
        r.task_index = 3'(idx);
        r.new_state = st;
        r.wake_at = wake;
        return r;
    endfunction

    task automatic post(input t_sched_req r);
        req_q.push_back(r);
        reqs_queued++;
    endtask

    // mostly well-formed traffic around a rising time base, some raw noise
    task automatic queue_random(input int n);
        t_sched_req r;
        int k;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 99);
            if (k < 3) begin
                // put every task to sleep, then tick through the wake-ups;
                // the first tick lands before any wake time, so idle is taken
                for (int t = 0; t < NT; t++)
                    post(set_req(t, ST_SLEEPING, base_now + $urandom_range(1, 40)));
                post(tick_req(base_now));
                for (int t = 0; t < 4; t++) begin
                    base_now += $urandom_range(0, 15);
                    post(tick_req(base_now));
                end
                j += NT + 4;
            end else if (k < 15) begin
                // raw noise over the whole field ranges
                r.action = 1'($urandom_range(0, 1));
                r.now_time = $urandom;
                r.task_index = 3'($urandom_range(0, 7));
                r.new_state = 2'($urandom_range(0, 3));
                r.wake_at = $urandom;
                post(r);
            end else if (k < 50) begin
                base_now += $urandom_range(0, 20);
                post(tick_req(base_now));
            end else begin
                post(set_req($urandom_range(0, 7), 2'($urandom_range(0, 2)),
                             base_now + $urandom_range(0, 60)));
            end
        end
    endtask

    // wait until every request is in and every pick is out, then let the block settle
    task automatic drain();
        while (reqs_taken != reqs_queued || pick_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // priority register write, only issued while the block is idle
    task automatic write_prio(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        prio_reg = v;
        prio_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // request driver: new payload only after the previous one was taken
    always @(negedge i_clk) begin : req_driver
        t_sched_req r;
        if (i_rst_n && (!i_valid || req_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (tx_odds != 0 && $urandom_range(1, 100) <= tx_odds) begin
                // burst of quiet cycles, this one included
                tx_gap = $urandom_range(0, 12);
                i_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                r = req_q.pop_front();
                i_action <= r.action;
                i_now_time <= r.now_time;
                i_task_index <= r.task_index;
                i_new_state <= r.new_state;
                i_wake_at <= r.wake_at;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure: random bursts plus an occasional long hold-off
    always @(negedge i_clk) begin : pick_stall
        if (hold_seen != hold_trig) begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else if (rx_odds != 0 && $urandom_range(1, 100) <= rx_odds) begin
            rx_gap = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: feed accepted requests to the shadow scheduler, check picks
    always @(posedge i_clk) begin : pick_monitor
        t_sched_req r;
        t_pick      want;
        if (i_rst_n) begin
            req_fire <= i_valid && !o_stall;
            quiet++;
            if (i_valid && !o_stall) begin
                r.action = i_action;
                r.now_time = i_now_time;
                r.task_index = i_task_index;
                r.new_state = i_new_state;
                r.wake_at = i_wake_at;
                schedule_step(r);
                reqs_taken++;
                quiet = 0;
            end
            if (i_cfg_valid && o_cfg_ready)
                quiet = 0;
            if (o_valid && !i_stall) begin
                quiet = 0;
                if (pick_q.size() == 0) begin
                    $error("pick with none pending: chosen_task %0d idle_fallback %0b",
                           o_chosen_task, o_idle_fallback);
                    fails++;
                end else begin
                    want = pick_q.pop_front();
                    picks_checked++;
                    if (want.idle)
                        idle_picks++;
                    if (o_chosen_task !== want.chosen) begin
                        $error("chosen_task: expected %0d, got %0d", want.chosen,
                               o_chosen_task);
                        fails++;
                    end
                    if (o_idle_fallback !== want.idle) begin
                        $error("idle_fallback: expected %0b, got %0b", want.idle,
                               o_idle_fallback);
                        fails++;
                    end
                end
            end
            if (quiet >= HANG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        // shadow reset
        prio_reg = PRIO_RESET;
        for (int i = 0; i < NT; i++) begin
            task_st[i] = ST_READY;
            task_wake[i] = '0;
            task_last[i] = '0;
        end
        cur_task = 0;
        cur_valid = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on the reset priorities
        tx_odds = 10;
        rx_odds = 10;
        post(tick_req(32'd0));                          // everyone ready, tie on prio 1
        post(set_req(1, ST_RUNNING, 32'd0));
        post(tick_req(32'd5));                          // stamps task 1
        post(set_req(2, ST_RUNNING, 32'hFFFF_FFFF));    // wake time ignored
        post(set_req(1, ST_READY, 32'h1234_5678));
        post(tick_req(32'd9));                          // oldest run wins the tie
        post(set_req(3, ST_SLEEPING, 32'hFFFF_FFFF));
        post(set_req(4, ST_SLEEPING, 32'd0));
        post(set_req(0, ST_BAD, 32'hFFFF_FFFF));        // ignored
        post(tick_req(32'd0));                          // wake at exactly now
        for (int t = 0; t < NT; t++)
            post(set_req(t, ST_SLEEPING, 32'hFFFF_FFFE));
        post(tick_req(32'd0));                          // nothing ready, idle taken
        post(tick_req(32'hFFFF_FFFF));                  // all wake at the top of time
        post(set_req(5, ST_SLEEPING, 32'h8000_0000));
        post(tick_req(32'h7FFF_FFFF));                  // one short of the wake time

        // random traffic, with the result side held off early on
        queue_random(200);
        hold_trig++;
        drain();

        // all priorities equal: pure least-recently-run order
        write_prio(32'h0000_0000);
        tx_odds = 5;
        rx_odds = 25;
        queue_random(200);
        drain();

        // everything at the weakest priority
        write_prio(32'hFFFF_FFFF);
        tx_odds = 25;
        rx_odds = 5;
        queue_random(200);
        drain();

        // few distinct levels, many ties; second long hold-off
        write_prio($urandom & 32'h3333_3333);
        tx_odds = 0;
        rx_odds = 0;
        queue_random(200);
        hold_trig++;
        drain();

        write_prio($urandom);
        tx_odds = 15;
        rx_odds = 15;
        queue_random(200);
        drain();

        // last stretch at full rate on both sides
        write_prio(32'h7654_3210);
        tx_odds = 0;
        rx_odds = 0;
        queue_random(250);
        drain();

        if (pick_q.size() != 0) begin
            $error("%0d picks never arrived", pick_q.size());
            fails++;
        end

        $display("run: %0d requests (%0d schedule ticks), %0d picks compared",
                 reqs_taken, ticks_taken, picks_checked);
        $display("run: %0d idle fallbacks, %0d priority writes, %0d mismatches",
                 idle_picks, prio_writes, fails);
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: priority_lru_task_scheduler_unit.f
design/plts_pkg.sv
design/plts_cell.sv
design/priority_lru_task_scheduler_unit.sv
verif/tb.sv
